// File: src/complex_magnitude_sorter_assert.svh
// Assertion macros used by the port-level checker of the complex magnitude sorter.
// Depends on nothing; included by name where assertions are written.
`ifndef COMPLEX_MAGNITUDE_SORTER_ASSERT_SVH
`define COMPLEX_MAGNITUDE_SORTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CMS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/cms_pkg.sv
// Shared types and constants of the complex magnitude sorter.
// Depends on nothing; used by cms_root, complex_magnitude_sorter and the sim files.
package cms_pkg;

	// Width of one Q4.12 part and of the modulus.
	localparam int DATA_W = 16;

	// Root bits produced for a 34-bit radicand, one per step.
	localparam int ROOT_STEPS = 17;

	// Default number of stored entries.
	localparam int CAPACITY_DEF = 64;

	// One stored entry: real part, imaginary part and modulus.
	typedef struct packed {
		logic [DATA_W-1:0] re;
		logic [DATA_W-1:0] im;
		logic [DATA_W-1:0] modulus;
	} entry_t;

endpackage

// File: src/cms_root.sv
// Iterative modulus unit: one shared multiplier squares both parts, then a
// restoring square root yields one root bit per cycle. Depends on cms_pkg.
module cms_root (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [cms_pkg::DATA_W-1:0] re,
	input  logic [cms_pkg::DATA_W-1:0] im,
	output logic                       done,
	output logic [cms_pkg::DATA_W-1:0] modulus
);

	localparam int SW = $clog2(cms_pkg::ROOT_STEPS);

	typedef enum logic [3:0] {
		R_IDLE = 4'b0001,
		R_SQRE = 4'b0010,
		R_SQIM = 4'b0100,
		R_ITER = 4'b1000
	} rstate_t;

	rstate_t                     state_q;
	logic [cms_pkg::DATA_W-1:0]  re_q;
	logic [cms_pkg::DATA_W-1:0]  im_q;
	logic [32:0]                 acc_q;
	logic [33:0]                 rad_q;
	logic [18:0]                 rem_q;
	logic [16:0]                 root_q;
	logic [SW-1:0]               step_q;
	logic                        done_q;

	logic [cms_pkg::DATA_W-1:0]  mul_op;
	logic [31:0]                 prod;
	logic [20:0]                 rem_pre;
	logic [20:0]                 trial;
	logic                        fits;

	// The single multiplier squares the real part first, then the imaginary part.
	assign mul_op = (state_q == R_SQIM) ? im_q : re_q;
	assign prod   = 32'(mul_op) * 32'(mul_op);

	// One restoring root step: bring down two radicand bits and try a one bit.
	assign rem_pre = {rem_q, rad_q[33:32]};
	assign trial   = {2'b00, root_q, 2'b01};
	assign fits    = (rem_pre >= trial);

	// Sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			// Done pulses for one cycle after the last root step.
			done_q <= (state_q == R_ITER) && (step_q == SW'(cms_pkg::ROOT_STEPS - 1));
			case (state_q)
				R_IDLE: begin
					if (start) begin
						state_q <= R_SQRE;
					end
				end
				R_SQRE: begin
					state_q <= R_SQIM;
				end
				R_SQIM: begin
					step_q  <= '0;
					state_q <= R_ITER;
				end
				R_ITER: begin
					if (step_q == SW'(cms_pkg::ROOT_STEPS - 1)) begin
						state_q <= R_IDLE;
					end else begin
						step_q <= step_q + SW'(1);
					end
				end
				default: begin
					state_q <= R_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			R_IDLE: begin
				re_q <= re;
				im_q <= im;
			end
			R_SQRE: begin
				acc_q <= {1'b0, prod};
			end
			R_SQIM: begin
				rad_q  <= {1'b0, acc_q + {1'b0, prod}};
				rem_q  <= '0;
				root_q <= '0;
			end
			R_ITER: begin
				rem_q  <= fits ? 19'(rem_pre - trial) : rem_pre[18:0];
				root_q <= {root_q[15:0], fits};
				rad_q  <= {rad_q[31:0], 2'b00};
			end
			default: begin
				rem_q <= rem_q;
			end
		endcase
	end

	// A root of 17 bits saturates to the largest 16-bit modulus.
	assign done    = done_q;
	assign modulus = root_q[16] ? '1 : root_q[15:0];

endmodule

// File: src/complex_magnitude_sorter.sv
// Top level of the complex magnitude sorter: entry memory, insertion sort
// and sorted emission. Depends on cms_pkg and cms_root.
//
//   channel  direction  handshake          payload
//   input    in         in_valid/in_stall  real_part, imag_part, final_item
//   output   out        out_valid/out_stall out_real, out_imag, modulus,
//                                          end_of_run, overflowed
//
// A stored item passes the modulus unit (both parts squared, 17 root steps,
// one handoff), then a read and a compare for each stored entry it is
// compared with (every larger modulus moves up one place, the first that is
// not larger ends the search), then a write. A dropped item (store full)
// skips the modulus unit. A sorted run reads each result, then loads it into
// the output register once that is free. in_stall is high from acceptance
// until the item and any run it starts are finished; reset empties the store.
module complex_magnitude_sorter #(
	parameter int CAPACITY = cms_pkg::CAPACITY_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [cms_pkg::DATA_W-1:0] real_part,
	input  logic [cms_pkg::DATA_W-1:0] imag_part,
	input  logic                       final_item,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [cms_pkg::DATA_W-1:0] out_real,
	output logic [cms_pkg::DATA_W-1:0] out_imag,
	output logic [cms_pkg::DATA_W-1:0] modulus,
	output logic                       end_of_run,
	output logic                       overflowed
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_ROOT = 7'b0000010,
		S_RD   = 7'b0000100,
		S_CMP  = 7'b0001000,
		S_PUT  = 7'b0010000,
		S_ERD  = 7'b0100000,
		S_EOUT = 7'b1000000
	} state_t;

	state_t                     state_q;
	logic [CW-1:0]              count_q;
	logic                       ovf_q;
	logic [AW-1:0]              idx_q;
	logic                       final_q;
	cms_pkg::entry_t            key_q;
	cms_pkg::entry_t            rdata_q;
	cms_pkg::entry_t            mem_q [CAPACITY];

	logic                       out_valid_q;
	cms_pkg::entry_t            out_q;
	logic                       out_end_q;
	logic                       out_ovf_q;

	logic                       in_take;
	logic                       has_room;
	logic                       root_start;
	logic                       root_done;
	logic [cms_pkg::DATA_W-1:0] root_mod;
	logic [AW-1:0]              rd_addr;
	logic                       wr_en;
	logic [AW-1:0]              wr_addr;
	cms_pkg::entry_t            wr_data;
	logic                       out_free;
	logic                       out_load;
	logic                       run_last;

	assign in_stall   = (state_q != S_IDLE);
	assign in_take    = in_valid && !in_stall;
	assign has_room   = (count_q < CW'(CAPACITY));
	assign root_start = in_take && has_room;
	assign out_free   = !out_valid_q || !out_stall;
	assign out_load   = (state_q == S_EOUT) && out_free;
	assign run_last   = (CW'(idx_q) == count_q - CW'(1));

	// Shared modulus unit.
	cms_root u_root (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (root_start),
		.re      (real_part),
		.im      (imag_part),
		.done    (root_done),
		.modulus (root_mod)
	);

	// The sort reads the entry below the insertion point; emission reads in order.
	assign rd_addr = (state_q == S_RD) ? idx_q - AW'(1) : idx_q;

	// Entries move up one place during the sort; the new entry lands last.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = key_q;
		if (state_q == S_CMP && rdata_q.modulus > key_q.modulus) begin
			wr_en   = 1'b1;
			wr_data = rdata_q;
		end else if (state_q == S_PUT) begin
			wr_en = 1'b1;
		end
	end

	// Entry memory with registered read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rdata_q <= mem_q[rd_addr];
	end

	// Sequencer and bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// The output register fills on a load and empties when taken.
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						if (has_room) begin
							state_q <= S_ROOT;
						end else begin
							ovf_q <= 1'b1;
							idx_q <= '0;
							if (final_item) begin
								state_q <= S_ERD;
							end
						end
					end
				end
				S_ROOT: begin
					if (root_done) begin
						idx_q   <= count_q[AW-1:0];
						state_q <= (count_q == '0) ? S_PUT : S_RD;
					end
				end
				S_RD: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (rdata_q.modulus > key_q.modulus) begin
						idx_q   <= idx_q - AW'(1);
						state_q <= (idx_q == AW'(1)) ? S_PUT : S_RD;
					end else begin
						state_q <= S_PUT;
					end
				end
				S_PUT: begin
					count_q <= count_q + CW'(1);
					if (final_q) begin
						idx_q   <= '0;
						state_q <= S_ERD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_ERD: begin
					state_q <= S_EOUT;
				end
				S_EOUT: begin
					if (out_free) begin
						if (run_last) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							idx_q   <= idx_q + AW'(1);
							state_q <= S_ERD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Item held while its modulus is computed and it is inserted.
	always_ff @(posedge clk) begin
		if (in_take) begin
			key_q.re <= real_part;
			key_q.im <= imag_part;
			final_q  <= final_item;
		end
		if (state_q == S_ROOT && root_done) begin
			key_q.modulus <= root_mod;
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q     <= rdata_q;
			out_end_q <= run_last;
			out_ovf_q <= ovf_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_real   = out_q.re;
	assign out_imag   = out_q.im;
	assign modulus    = out_q.modulus;
	assign end_of_run = out_end_q;
	assign overflowed = out_ovf_q;

endmodule

// File: src/cms_checker.sv
// Port-level checker of the complex magnitude sorter and its bind.
// Depends on complex_magnitude_sorter_assert.svh and the top level's ports.
`include "complex_magnitude_sorter_assert.svh"

module cms_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        final_item,
	input logic        out_valid,
	input logic        out_stall,
	input logic [15:0] out_real,
	input logic [15:0] out_imag,
	input logic [15:0] modulus,
	input logic        end_of_run,
	input logic        overflowed
);

	logic [33:0] sum_sq;
	logic [33:0] mod_sq;
	logic [33:0] mod_next_sq;

	assign sum_sq      = 34'(out_real) * 34'(out_real) + 34'(out_imag) * 34'(out_imag);
	assign mod_sq      = 34'(modulus) * 34'(modulus);
	assign mod_next_sq = (34'(modulus) + 34'd1) * (34'(modulus) + 34'd1);

	// A stalled result keeps its fields.
	`CMS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(out_real) && $stable(out_imag) && $stable(modulus)
			&& $stable(end_of_run) && $stable(overflowed),
		"stalled result changed")

	// Every unsaturated modulus is the floor root of the sum of squares.
	`CMS_ASSERT_NOW(a_mod_root, clk, arst_n, out_valid && modulus != 16'hFFFF,
		mod_sq <= sum_sq && sum_sq < mod_next_sq, "modulus is not the floor root")

	// A final item always keeps the block busy in the next cycle.
	`CMS_ASSERT_NEXT(a_final_busy, clk, arst_n, in_valid && !in_stall && final_item,
		in_stall, "final item did not start work")

	// A new result is only loaded while the input is held off.
	`CMS_ASSERT_NEXT(a_out_rise, clk, arst_n, !out_valid && !in_stall,
		!out_valid, "result appeared while the input was open")

endmodule

bind complex_magnitude_sorter cms_checker u_cms_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.final_item (final_item),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.out_real   (out_real),
	.out_imag   (out_imag),
	.modulus    (modulus),
	.end_of_run (end_of_run),
	.overflowed (overflowed)
);

// File: sim/complex_magnitude_sorter_checker.sv
// Result checker for the complex magnitude sorter: follows every accepted item,
// predicts each sorted run and compares every result that leaves the block.
// Depends on cms_pkg for the entry layout and the field widths.
module complex_magnitude_sorter_checker #(
	parameter int CAPACITY = cms_pkg::CAPACITY_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic [cms_pkg::DATA_W-1:0] real_part,
	input  logic [cms_pkg::DATA_W-1:0] imag_part,
	input  logic                       final_item,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic [cms_pkg::DATA_W-1:0] out_real,
	input  logic [cms_pkg::DATA_W-1:0] out_imag,
	input  logic [cms_pkg::DATA_W-1:0] modulus,
	input  logic                       end_of_run,
	input  logic                       overflowed,
	output int                         mismatches,
	output int                         outstanding
);
	import cms_pkg::*;

	// One predicted result: the entry plus the two run flags.
	typedef struct packed {
		entry_t entry;
		logic   last;
		logic   dropped;
	} sorted_result_t;

	// Entries of the current set, always kept in ascending modulus order.
	entry_t         sorted_set[$];
	logic           set_overflow;
	// Results predicted but not yet seen on the output.
	sorted_result_t run_queue[$];

	// Floor square root of re^2 + im^2, found one root bit at a time from the top.
	function automatic logic [DATA_W-1:0] modulus_of(input logic [DATA_W-1:0] re,
			input logic [DATA_W-1:0] im);
		logic [32:0] sum_sq;
		logic [33:0] trial_sq;
		logic [16:0] root;
		logic [16:0] trial;
		sum_sq = 33'(re) * 33'(re) + 33'(im) * 33'(im);
		root = '0;
		for (int b = 16; b >= 0; b--) begin
			trial = root | (17'd1 << b);
			trial_sq = 34'(trial) * 34'(trial);
			if (trial_sq <= 34'(sum_sq))
				root = trial;
		end
		// Roots beyond 16 bits saturate and sort as the saturated value.
		return (root > 17'h0FFFF) ? 16'hFFFF : root[DATA_W-1:0];
	endfunction

	// Store an accepted item and, on a final item, queue the whole sorted run.
	task automatic take_item(input logic [DATA_W-1:0] re, input logic [DATA_W-1:0] im,
			input logic fin);
		entry_t         fresh;
		sorted_result_t res;
		int             pos;
		if (sorted_set.size() < CAPACITY) begin
			fresh.re = re;
			fresh.im = im;
			fresh.modulus = modulus_of(re, im);
			// Insert behind every entry with an equal modulus so ties keep arrival order.
			pos = sorted_set.size();
			for (int k = 0; k < sorted_set.size(); k++) begin
				if (sorted_set[k].modulus > fresh.modulus) begin
					pos = k;
					break;
				end
			end
			sorted_set.insert(pos, fresh);
		end else begin
			set_overflow = 1'b1;
		end
		if (fin) begin
			foreach (sorted_set[k]) begin
				res.entry = sorted_set[k];
				res.last = (k == sorted_set.size() - 1);
				res.dropped = set_overflow;
				run_queue.push_back(res);
			end
			sorted_set.delete();
			set_overflow = 1'b0;
		end
	endtask

	// Compare one accepted result with the oldest prediction.
	task automatic check_result();
		sorted_result_t want;
		if (run_queue.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: unexpected result re %h im %h mod %h last %b ovf %b",
					$realtime, out_real, out_imag, modulus, end_of_run, overflowed);
		end else begin
			want = run_queue.pop_front();
			if (out_real !== want.entry.re || out_imag !== want.entry.im ||
					modulus !== want.entry.modulus || end_of_run !== want.last ||
					overflowed !== want.dropped) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"%0t: mismatch want re %h im %h mod %h last %b ovf %b,",
						" got re %h im %h mod %h last %b ovf %b"}, $realtime,
						want.entry.re, want.entry.im, want.entry.modulus, want.last,
						want.dropped, out_real, out_imag, modulus, end_of_run, overflowed);
			end
		end
	endtask

	// Watch both channels at the rising edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sorted_set.delete();
			run_queue.delete();
			set_overflow = 1'b0;
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (out_valid === 1'b1 && out_stall === 1'b0)
				check_result();
			if (in_valid === 1'b1 && in_stall === 1'b0)
				take_item(real_part, imag_part, final_item);
			outstanding = run_queue.size();
		end
	end

endmodule

// File: sim/complex_magnitude_sorter_tb.sv
// Testbench top of the complex magnitude sorter: clock, reset, item stimulus,
// output stalling, watchdog and verdict. Depends on cms_pkg, the block and
// complex_magnitude_sorter_checker.
module complex_magnitude_sorter_tb;
	import cms_pkg::*;

	localparam int IDLE_LIMIT  = 3000;
	localparam int HOLD_CYCLES = 400;
	localparam int HOLD_AFTER  = 30;
	localparam int TAIL_CYCLES = 50;

	// How the output side behaves over one stretch of cycles.
	typedef enum int {STALL_NONE, STALL_CHOPPY, STALL_HEAVY} stall_mode_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [DATA_W-1:0] real_part = '0;
	logic [DATA_W-1:0] imag_part = '0;
	logic              final_item = 1'b0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [DATA_W-1:0] out_real;
	logic [DATA_W-1:0] out_imag;
	logic [DATA_W-1:0] modulus;
	logic              end_of_run;
	logic              overflowed;

	int                mismatches;
	int                outstanding;
	int                results_taken = 0;
	int                idle_cycles = 0;
	int                burst_left = 0;
	logic [DATA_W-1:0] prev_re = '0;
	logic [DATA_W-1:0] prev_im = '0;

	complex_magnitude_sorter u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.real_part  (real_part),
		.imag_part  (imag_part),
		.final_item (final_item),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_real   (out_real),
		.out_imag   (out_imag),
		.modulus    (modulus),
		.end_of_run (end_of_run),
		.overflowed (overflowed)
	);

	complex_magnitude_sorter_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.real_part   (real_part),
		.imag_part   (imag_part),
		.final_item  (final_item),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_real    (out_real),
		.out_imag    (out_imag),
		.modulus     (modulus),
		.end_of_run  (end_of_run),
		.overflowed  (overflowed),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Watchdog on cycles without any handshake, plus a count of taken results.
	always @(posedge clk) begin
		if ((in_valid === 1'b1 && in_stall === 1'b0) ||
				(out_valid === 1'b1 && out_stall === 1'b0)) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (out_valid === 1'b1 && out_stall === 1'b0)
			results_taken <= results_taken + 1;
	end

	// Output side: random stretches of stalling, and one long hold-off that
	// lets the block back up onto its input.
	initial begin
		stall_mode_t mode;
		int          stretch;
		bit          hold_done;
		hold_done = 1'b0;
		@(negedge clk);
		forever begin
			if (!hold_done && results_taken >= HOLD_AFTER) begin
				hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				mode = stall_mode_t'($urandom_range(0, 2));
				stretch = $urandom_range(5, 40);
				repeat (stretch) begin
					case (mode)
						STALL_NONE: begin
							out_stall <= 1'b0;
						end
						STALL_CHOPPY: begin
							out_stall <= 1'($urandom_range(0, 1));
						end
						default: begin
							out_stall <= ($urandom_range(0, 3) != 0);
						end
					endcase
					@(negedge clk);
				end
			end
		end
	end

	// Offer one item, opening a new burst after a random gap when the last
	// one is used up. Returns at the falling edge after acceptance.
	task automatic offer(input logic [DATA_W-1:0] re, input logic [DATA_W-1:0] im,
			input logic fin);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 8);
			in_valid <= 1'b0;
			real_part <= DATA_W'($urandom);
			imag_part <= DATA_W'($urandom);
			final_item <= 1'($urandom_range(0, 1));
			repeat (gap) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 50) :
				$urandom_range(1, 8);
		end
		real_part <= re;
		imag_part <= im;
		final_item <= fin;
		in_valid <= 1'b1;
		burst_left--;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		@(negedge clk);
	endtask

	// Stop offering until every predicted result has been taken.
	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	// One part: mostly in range, some full 16-bit values, small values and edges.
	function automatic logic [DATA_W-1:0] random_part();
		int kind;
		kind = $urandom_range(0, 9);
		if (kind <= 4)
			return DATA_W'($urandom_range(0, 40959));
		else if (kind <= 6)
			return DATA_W'($urandom);
		else if (kind == 7)
			return DATA_W'($urandom_range(0, 15));
		case ($urandom_range(0, 3))
			0: return 16'd0;
			1: return 16'd40959;
			2: return 16'hFFFF;
			default: return 16'h8000;
		endcase
	endfunction

	// A set of random numbers closed by a final item; some numbers are the
	// previous one swapped, which gives equal moduli.
	task automatic send_set(input int count);
		logic [DATA_W-1:0] re;
		logic [DATA_W-1:0] im;
		for (int k = 1; k <= count; k++) begin
			if ($urandom_range(0, 5) == 0) begin
				re = prev_im;
				im = prev_re;
			end else begin
				re = random_part();
				im = random_part();
			end
			prev_re = re;
			prev_im = im;
			offer(re, im, k == count);
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Single-entry sets: zero, and the largest parts with a saturated modulus.
		offer(16'd0, 16'd0, 1'b1);
		offer(16'hFFFF, 16'hFFFF, 1'b1);
		// Range limits arriving out of order, with two pairs of equal moduli.
		offer(16'd40959, 16'd0, 1'b0);
		offer(16'd0, 16'd40959, 1'b0);
		offer(16'd40959, 16'd40959, 1'b0);
		offer(16'd4096, 16'd0, 1'b0);
		offer(16'd0, 16'd4096, 1'b1);
		// Alternating bit patterns, equal moduli.
		offer(16'hAAAA, 16'h5555, 1'b0);
		offer(16'h5555, 16'hAAAA, 1'b1);
		// Small values and a large one in front of them.
		offer(16'h8000, 16'h0001, 1'b0);
		offer(16'd1, 16'd0, 1'b0);
		offer(16'd0, 16'd1, 1'b0);
		offer(16'd3, 16'd4, 1'b1);
		// Moduli right at and past the saturation point, tied at the top.
		offer(16'hFFFF, 16'd0, 1'b0);
		offer(16'd0, 16'hFFFF, 1'b0);
		offer(16'hFFFF, 16'hFFFF, 1'b0);
		offer(16'hB504, 16'hB505, 1'b0);
		offer(16'd1, 16'd1, 1'b1);
		drain();

		// Random sets with a pause midway; one set fills the store and
		// overflows so that its final item is dropped.
		for (int s = 0; s < 14; s++) begin
			if (s == 10) begin
				send_set(CAPACITY_DEF + 1);
			end else begin
				send_set($urandom_range(1, 5));
			end
			if (s == 5) begin
				drain();
			end
		end
		drain();
		repeat (TAIL_CYCLES) @(negedge clk);

		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
